// ===== hdl/skvt_pkg.sv =====
`default_nettype none

package skvt_pkg;

  // default table depth
  localparam int unsigned CAPACITY_DEF = 16;

  // field widths
  localparam int unsigned KEY_W = 32;
  localparam int unsigned VAL_W = 32;

  // request codes
  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_UPDATE = 3'd1,
    OP_UPSERT = 3'd2,
    OP_ERASE  = 3'd3,
    OP_LOOKUP = 3'd4,
    OP_RANK   = 3'd5
  } op_t;

  // result codes
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NOT_FOUND  = 3'd1,
    ST_PRESENT    = 3'd2,
    ST_FULL       = 3'd3,
    ST_RANK_RANGE = 3'd4
  } status_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_EXEC,
    S_SHUP,
    S_SHDN,
    S_PUT,
    S_RANK,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

// ===== hdl/skvt_ram.sv =====
`default_nettype none

module skvt_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== hdl/sorted_key_value_table.sv =====
`default_nettype none

// Sorted key/value table: up to CAPACITY distinct 32-bit keys with 32-bit
// values, held in ascending key order in one RAM (key and value side by
// side, registered read). One request is worked on at a time and gives
// exactly one result beat. Key requests scan the stored entries from the
// bottom, one per cycle, until the key or a larger key turns up; insert
// and erase then move every entry above the place by one slot, one per
// cycle through the single read and write port. The result sits in an
// output register, so the next request is taken as soon as the sequencer
// is idle, even while that beat is stalled.
module sorted_key_value_table
  import skvt_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_op,
  input  wire logic [31:0] in_key,
  input  wire logic [31:0] in_value,
  input  wire logic [3:0]  in_rank,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_status,
  output logic [31:0]      out_found_key,
  output logic [31:0]      out_found_value,
  output logic [4:0]       out_entry_count
);

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned EW = KEY_W + VAL_W;

  // control state
  state_t          state_r, state_nxt;
  logic [CW-1:0]   occ_r, occ_nxt;
  logic            out_valid_r, out_valid_nxt;

  // request and working registers
  op_t             op_r, op_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [VAL_W-1:0] val_r, val_nxt;
  logic [IW-1:0]   addr_r, addr_nxt;
  logic [IW-1:0]   cmp_r, cmp_nxt;
  logic [IW-1:0]   idx_r, idx_nxt;
  logic            hit_r, hit_nxt;
  status_t         status_r, status_nxt;
  logic [KEY_W-1:0] fkey_r, fkey_nxt;
  logic [VAL_W-1:0] fval_r, fval_nxt;

  // result register
  logic [2:0]       out_status_r, out_status_nxt;
  logic [KEY_W-1:0] out_key_r, out_key_nxt;
  logic [VAL_W-1:0] out_val_r, out_val_nxt;
  logic [4:0]       out_cnt_r, out_cnt_nxt;

  // memory port
  logic            mem_we;
  logic [IW-1:0]   mem_wa;
  logic [EW-1:0]   mem_wd;
  logic [IW-1:0]   rd_addr;
  logic [EW-1:0]   rd_data;
  logic [KEY_W-1:0] rd_key;
  logic [VAL_W-1:0] rd_val;

  // helpers
  logic [CW-1:0]   occ_m1;
  logic [IW-1:0]   last_idx;
  logic [IW-1:0]   occ_lo;
  logic            full;
  logic [IW+3:0]   rank_ext;
  logic [IW+3:0]   occ_ext;
  logic            rank_ok;
  logic [CW+4:0]   cnt_ext;
  logic            out_free;
  logic            ins_path;
  op_t             in_op_t;

  skvt_ram #(
    .WIDTH (EW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_wa),
    .wr_data (mem_wd),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rd_key   = rd_data[EW-1:VAL_W];
  assign rd_val   = rd_data[VAL_W-1:0];
  assign occ_m1   = occ_r - CW'(1);
  assign last_idx = occ_m1[IW-1:0];
  assign occ_lo   = occ_r[IW-1:0];
  assign full     = (occ_r == CW'(CAPACITY));
  assign rank_ext = {{IW{1'b0}}, in_rank};
  assign occ_ext  = {{(IW + 4 - CW){1'b0}}, occ_r};
  assign rank_ok  = (rank_ext < occ_ext);
  assign cnt_ext  = {5'b0, occ_r};
  assign out_free = !out_valid_r || !out_stall;
  assign in_op_t  = op_t'(in_op);

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_key   = out_key_r;
  assign out_found_value = out_val_r;
  assign out_entry_count = out_cnt_r;

  // sequencer: next state, memory accesses and result
  always_comb begin
    state_nxt      = state_r;
    occ_nxt        = occ_r;
    out_valid_nxt  = out_valid_r && out_stall;
    op_nxt         = op_r;
    key_nxt        = key_r;
    val_nxt        = val_r;
    addr_nxt       = addr_r;
    cmp_nxt        = cmp_r;
    idx_nxt        = idx_r;
    hit_nxt        = hit_r;
    status_nxt     = status_r;
    fkey_nxt       = fkey_r;
    fval_nxt       = fval_r;
    out_status_nxt = out_status_r;
    out_key_nxt    = out_key_r;
    out_val_nxt    = out_val_r;
    out_cnt_nxt    = out_cnt_r;
    mem_we         = 1'b0;
    mem_wa         = idx_r;
    mem_wd         = {key_r, val_r};
    rd_addr        = addr_r;
    ins_path       = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        // first read goes out with the accepted beat
        rd_addr = (in_op_t == OP_RANK) ? rank_ext[IW-1:0] : '0;
        if (in_valid) begin
          op_nxt     = in_op_t;
          key_nxt    = in_key;
          val_nxt    = in_value;
          hit_nxt    = 1'b0;
          fkey_nxt   = '0;
          fval_nxt   = '0;
          status_nxt = ST_OK;
          case (in_op_t) inside
            OP_INSERT, OP_UPDATE, OP_UPSERT, OP_ERASE, OP_LOOKUP: begin
              if (occ_r == '0) begin
                idx_nxt   = '0;
                state_nxt = S_EXEC;
              end else begin
                cmp_nxt   = '0;
                addr_nxt  = (last_idx == '0) ? '0 : IW'(1);
                state_nxt = S_SCAN;
              end
            end
            OP_RANK: begin
              if (rank_ok) begin
                state_nxt = S_RANK;
              end else begin
                status_nxt = ST_RANK_RANGE;
                state_nxt  = S_DONE;
              end
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end

      S_SCAN: begin
        // one entry compared per cycle, next read already in flight
        rd_addr  = addr_r;
        addr_nxt = (addr_r == last_idx) ? addr_r : addr_r + IW'(1);
        cmp_nxt  = addr_r;
        if (rd_key == key_r) begin
          hit_nxt   = 1'b1;
          idx_nxt   = cmp_r;
          if (op_r == OP_LOOKUP) begin
            fval_nxt = rd_val;
          end
          state_nxt = S_EXEC;
        end else if (rd_key > key_r) begin
          idx_nxt   = cmp_r;
          state_nxt = S_EXEC;
        end else if (cmp_r == last_idx) begin
          idx_nxt   = occ_lo;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        state_nxt = S_DONE;
        case (op_r)
          OP_LOOKUP: status_nxt = hit_r ? ST_OK : ST_NOT_FOUND;
          OP_UPDATE: begin
            if (hit_r) begin
              state_nxt = S_PUT;
            end else begin
              status_nxt = ST_NOT_FOUND;
            end
          end
          OP_UPSERT: begin
            if (hit_r) begin
              state_nxt = S_PUT;
            end else begin
              ins_path = 1'b1;
            end
          end
          OP_INSERT: begin
            if (hit_r) begin
              status_nxt = ST_PRESENT;
            end else begin
              ins_path = 1'b1;
            end
          end
          OP_ERASE: begin
            if (!hit_r) begin
              status_nxt = ST_NOT_FOUND;
            end else if (idx_r == last_idx) begin
              occ_nxt    = occ_m1;
              status_nxt = ST_OK;
            end else begin
              // move entries above the key down by one
              rd_addr   = idx_r + IW'(1);
              cmp_nxt   = idx_r + IW'(1);
              addr_nxt  = (idx_r + IW'(1) == last_idx) ? last_idx : idx_r + IW'(2);
              state_nxt = S_SHDN;
            end
          end
          default: status_nxt = ST_OK;
        endcase

        if (ins_path) begin
          if (full) begin
            status_nxt = ST_FULL;
          end else if (idx_r == occ_lo) begin
            state_nxt = S_PUT;
          end else begin
            // move entries from the top down to the slot up by one
            rd_addr   = last_idx;
            cmp_nxt   = last_idx;
            addr_nxt  = (last_idx == idx_r) ? last_idx : last_idx - IW'(1);
            state_nxt = S_SHUP;
          end
        end
      end

      S_SHUP: begin
        rd_addr  = addr_r;
        addr_nxt = (addr_r == idx_r) ? addr_r : addr_r - IW'(1);
        cmp_nxt  = addr_r;
        mem_we   = 1'b1;
        mem_wa   = cmp_r + IW'(1);
        mem_wd   = rd_data;
        if (cmp_r == idx_r) begin
          state_nxt = S_PUT;
        end
      end

      S_SHDN: begin
        rd_addr  = addr_r;
        addr_nxt = (addr_r == last_idx) ? addr_r : addr_r + IW'(1);
        cmp_nxt  = addr_r;
        mem_we   = 1'b1;
        mem_wa   = cmp_r - IW'(1);
        mem_wd   = rd_data;
        if (cmp_r == last_idx) begin
          occ_nxt    = occ_m1;
          status_nxt = ST_OK;
          state_nxt  = S_DONE;
        end
      end

      S_PUT: begin
        // new entry or new value at the slot; a miss here is an insert
        mem_we = 1'b1;
        if (!hit_r) begin
          occ_nxt = occ_r + CW'(1);
        end
        status_nxt = ST_OK;
        state_nxt  = S_DONE;
      end

      S_RANK: begin
        fkey_nxt   = rd_key;
        fval_nxt   = rd_val;
        status_nxt = ST_OK;
        state_nxt  = S_DONE;
      end

      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_key_nxt    = fkey_r;
          out_val_nxt    = fval_r;
          out_cnt_nxt    = cnt_ext[4:0];
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working and result registers
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    val_r        <= val_nxt;
    addr_r       <= addr_nxt;
    cmp_r        <= cmp_nxt;
    idx_r        <= idx_nxt;
    hit_r        <= hit_nxt;
    status_r     <= status_nxt;
    fkey_r       <= fkey_nxt;
    fval_r       <= fval_nxt;
    out_status_r <= out_status_nxt;
    out_key_r    <= out_key_nxt;
    out_val_r    <= out_val_nxt;
    out_cnt_r    <= out_cnt_nxt;
  end

`ifndef NO_ASSERTIONS
  // count never passes the depth
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // count changes only when leaving a state that commits a request
  a_occ_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_PUT && state_r != S_EXEC && state_r != S_SHDN) |=> $stable(occ_r))
    else $error("entry count changed outside a commit");

  // memory is written only while moving entries or placing one
  a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_SHUP || state_r == S_SHDN || state_r == S_PUT))
    else $error("memory write outside a write state");

  // a result beat only appears from the result state
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result beat without a finished request");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_sorted_key_value_table.sv =====
`default_nettype none

module tb_sorted_key_value_table;
  import skvt_pkg::*;

  localparam int unsigned TBL_DEPTH = CAPACITY_DEF;
  localparam int unsigned POOL_SIZE = 24;
  localparam int unsigned PHASES = 12;
  localparam int unsigned PHASE_LEN = 50;
  localparam int unsigned DRAIN_CYCLES = 2 * TBL_DEPTH + 8;
  localparam int unsigned IDLE_LIMIT = 4000;

  // spare request codes, no operation
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;

  // mix of requests per phase
  localparam int MIX_FILL  = 0;
  localparam int MIX_MIXED = 1;
  localparam int MIX_DRAIN = 2;

  typedef struct packed {
    status_t     status;
    logic [31:0] found_key;
    logic [31:0] found_value;
    logic [4:0]  entry_count;
  } kv_result_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] key;
    logic [31:0] value;
    logic [3:0]  rank;
    logic        typed;
    kv_result_t  want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_op;
  logic [31:0] in_key;
  logic [31:0] in_value;
  logic [3:0]  in_rank;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_status;
  logic [31:0] out_found_key;
  logic [31:0] out_found_value;
  logic [4:0]  out_entry_count;

  // predictor copy of the table
  logic [31:0] tbl_key [TBL_DEPTH];
  logic [31:0] tbl_val [TBL_DEPTH];
  logic [4:0]  tbl_occ;

  kv_result_t  pending_results [$];
  logic [31:0] key_pool [POOL_SIZE];
  int          mismatch_count = 0;
  int          stall_left = 0;
  int          idle_cycles = 0;
  bit          quiet = 1'b0;

  // directed requests: reset state, extremes, error codes
  dir_row_t dir_rows [0:19] = '{
    '{OP_LOOKUP, 32'h0, 32'h0, 4'd0, 1'b1, '{ST_NOT_FOUND, 32'h0, 32'h0, 5'd0}},
    '{OP_RANK, 32'h0, 32'h0, 4'd0, 1'b1, '{ST_RANK_RANGE, 32'h0, 32'h0, 5'd0}},
    '{OP_ERASE, 32'h5, 32'h0, 4'd0, 1'b1, '{ST_NOT_FOUND, 32'h0, 32'h0, 5'd0}},
    '{OP_UPDATE, 32'h5, 32'h1234, 4'd0, 1'b1, '{ST_NOT_FOUND, 32'h0, 32'h0, 5'd0}},
    '{OP_SPARE6, 32'h0, 32'h0, 4'd0, 1'b1, '{ST_OK, 32'h0, 32'h0, 5'd0}},
    '{OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd0, 1'b1,
      '{ST_OK, 32'h0, 32'h0, 5'd1}},
    '{OP_INSERT, 32'h0, 32'h0, 4'd0, 1'b1, '{ST_OK, 32'h0, 32'h0, 5'd2}},
    '{OP_INSERT, 32'h0, 32'h1, 4'd0, 1'b1, '{ST_PRESENT, 32'h0, 32'h0, 5'd2}},
    '{OP_RANK, 32'h0, 32'h0, 4'd0, 1'b1, '{ST_OK, 32'h0, 32'h0, 5'd2}},
    '{OP_RANK, 32'h0, 32'h0, 4'd1, 1'b1,
      '{ST_OK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd2}},
    '{OP_RANK, 32'h0, 32'h0, 4'd15, 1'b1, '{ST_RANK_RANGE, 32'h0, 32'h0, 5'd2}},
    '{OP_RANK, 32'h0, 32'h0, 4'd2, 1'b1, '{ST_RANK_RANGE, 32'h0, 32'h0, 5'd2}},
    '{OP_UPSERT, 32'h8000_0000, 32'hA5A5_A5A5, 4'd0, 1'b0, '0},
    '{OP_UPSERT, 32'h0, 32'h5A5A_5A5A, 4'd0, 1'b0, '0},
    '{OP_LOOKUP, 32'h0, 32'h0, 4'd0, 1'b0, '0},
    '{OP_UPDATE, 32'hFFFF_FFFF, 32'h1, 4'd0, 1'b0, '0},
    '{OP_RANK, 32'h0, 32'h0, 4'd1, 1'b0, '0},
    '{OP_ERASE, 32'h8000_0000, 32'h0, 4'd0, 1'b0, '0},
    '{OP_LOOKUP, 32'h8000_0000, 32'h0, 4'd0, 1'b1,
      '{ST_NOT_FOUND, 32'h0, 32'h0, 5'd2}},
    '{OP_SPARE7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15, 1'b1,
      '{ST_OK, 32'h0, 32'h0, 5'd2}}
  };

  sorted_key_value_table DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_op           (in_op),
    .in_key          (in_key),
    .in_value        (in_value),
    .in_rank         (in_rank),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_found_key   (out_found_key),
    .out_found_value (out_found_value),
    .out_entry_count (out_entry_count)
  );

  always #6 clk = ~clk;

  // apply one request to the predictor table, return the expected beat
  function automatic kv_result_t apply_request(input logic [2:0] op,
                                               input logic [31:0] key,
                                               input logic [31:0] val,
                                               input logic [3:0] rank);
    kv_result_t res;
    int hit;
    int pos;
    res = '0;
    res.status = ST_OK;
    hit = -1;
    for (int i = 0; i < tbl_occ; i++)
      if (tbl_key[i] == key) hit = i;
    case (op)
      OP_INSERT, OP_UPSERT: begin
        if (hit >= 0) begin
          // upsert falls back to update when the key is there
          if (op == OP_UPSERT) tbl_val[hit] = val;
          else res.status = ST_PRESENT;
        end else if (tbl_occ >= TBL_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          pos = 0;
          while (pos < tbl_occ && tbl_key[pos] < key) pos++;
          for (int j = tbl_occ; j > pos; j--) begin
            tbl_key[j] = tbl_key[j-1];
            tbl_val[j] = tbl_val[j-1];
          end
          tbl_key[pos] = key;
          tbl_val[pos] = val;
          tbl_occ++;
        end
      end
      OP_UPDATE: begin
        if (hit < 0) res.status = ST_NOT_FOUND;
        else tbl_val[hit] = val;
      end
      OP_ERASE: begin
        if (hit < 0) begin
          res.status = ST_NOT_FOUND;
        end else begin
          for (int j = hit; j + 1 < tbl_occ; j++) begin
            tbl_key[j] = tbl_key[j+1];
            tbl_val[j] = tbl_val[j+1];
          end
          tbl_occ--;
        end
      end
      OP_LOOKUP: begin
        if (hit < 0) res.status = ST_NOT_FOUND;
        else res.found_value = tbl_val[hit];
      end
      OP_RANK: begin
        if (rank >= tbl_occ) begin
          res.status = ST_RANK_RANGE;
        end else begin
          res.found_key = tbl_key[rank];
          res.found_value = tbl_val[rank];
        end
      end
      default: ;
    endcase
    res.entry_count = tbl_occ;
    return res;
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 40) $display("[tb] mismatch at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // drive one request beat and book its expected result once accepted
  task automatic issue_request(input logic [2:0] op, input logic [31:0] key,
                               input logic [31:0] val, input logic [3:0] rank,
                               input logic typed, input kv_result_t typed_res);
    int gap;
    kv_result_t res;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_op = op;
    in_key = key;
    in_value = val;
    in_rank = rank;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    res = apply_request(op, key, val, rank);
    if (typed) res = typed_res;
    pending_results.push_back(res);
  endtask

  task automatic wait_results_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // result-side back-pressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_stall = 1'b1;
    end else begin
      stall_left = pick_gap();
      out_stall = (stall_left > 0);
      if (stall_left > 0) stall_left = stall_left - 1;
    end
  end

  // compare each result beat with the oldest expectation
  always @(posedge clk) begin : result_check
    kv_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d", out_status, want.status));
        if (out_found_key !== want.found_key)
          report_mismatch($sformatf("found_key got %h want %h",
                                    out_found_key, want.found_key));
        if (out_found_value !== want.found_value)
          report_mismatch($sformatf("found_value got %h want %h",
                                    out_found_value, want.found_value));
        if (out_entry_count !== want.entry_count)
          report_mismatch($sformatf("entry_count got %0d want %0d",
                                    out_entry_count, want.entry_count));
      end
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles = idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[sorted_key_value_table] ERROR");
      $finish;
    end
  end

  initial begin
    int mix;
    int r;
    logic [2:0] op;
    logic [31:0] key;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = '0;
    in_key = '0;
    in_value = '0;
    in_rank = '0;
    out_stall = 1'b0;
    tbl_occ = '0;
    foreach (tbl_key[i]) begin
      tbl_key[i] = '0;
      tbl_val[i] = '0;
    end
    // small key set so that hits, full table and erasures are common
    foreach (key_pool[i]) key_pool[i] = $urandom;
    key_pool[0] = 32'h0;
    key_pool[1] = 32'hFFFF_FFFF;
    key_pool[2] = 32'h8000_0000;
    key_pool[3] = 32'h7FFF_FFFF;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed part
    foreach (dir_rows[i])
      issue_request(dir_rows[i].op, dir_rows[i].key, dir_rows[i].value,
                    dir_rows[i].rank, dir_rows[i].typed, dir_rows[i].want);
    @(negedge clk);
    in_valid = 1'b0;
    wait_results_drained();

    // random part: phases that fill, mix and drain the table
    for (int p = 0; p < PHASES; p++) begin
      mix = p % 3;
      quiet = (p % 4 == 3);
      for (int n = 0; n < PHASE_LEN; n++) begin
        r = $urandom_range(0, 99);
        if (mix == MIX_FILL) begin
          if (r < 45) op = OP_INSERT;
          else if (r < 65) op = OP_UPSERT;
          else if (r < 72) op = OP_UPDATE;
          else if (r < 80) op = OP_LOOKUP;
          else if (r < 89) op = OP_RANK;
          else if (r < 96) op = OP_ERASE;
          else op = (r < 98) ? OP_SPARE6 : OP_SPARE7;
        end else if (mix == MIX_DRAIN) begin
          if (r < 45) op = OP_ERASE;
          else if (r < 55) op = OP_INSERT;
          else if (r < 65) op = OP_LOOKUP;
          else if (r < 75) op = OP_RANK;
          else if (r < 85) op = OP_UPDATE;
          else if (r < 95) op = OP_UPSERT;
          else op = (r < 97) ? OP_SPARE6 : OP_SPARE7;
        end else begin
          op = (r < 95) ? 3'($urandom_range(0, 5)) : 3'($urandom_range(6, 7));
        end
        if ($urandom_range(0, 9) == 0) key = $urandom;
        else key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        issue_request(op, key, $urandom, 4'($urandom_range(0, 15)), 1'b0, '0);
      end
      // hold the sender off until every result is back
      @(negedge clk);
      in_valid = 1'b0;
      wait_results_drained();
    end

    quiet = 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("[sorted_key_value_table] OK");
    end else begin
      $display("[sorted_key_value_table] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sorted_key_value_table.f =====
hdl/skvt_pkg.sv
hdl/skvt_ram.sv
hdl/sorted_key_value_table.sv
tb/tb_sorted_key_value_table.sv
